// File: sv/pns_pkg.sv
package pns_pkg;

   localparam int ValueWidth  = 32;
   localparam int DivWidth    = ValueWidth / 2 + 1;
   localparam int SqWidth     = ValueWidth + 2;
   localparam int StepWidth   = 4;
   localparam int DivCntWidth = $clog2(ValueWidth);

   typedef struct packed {
      logic                  op;
      logic [ValueWidth-1:0] start_value;
   } pns_req_type;

   typedef struct packed {
      logic                  found;
      logic [ValueWidth-1:0] prime_value;
   } pns_rsp_type;

   typedef enum logic [3:0] {
      DP_NOP        = 4'd0,
      DP_LOAD       = 4'd1,
      DP_STEP       = 4'd2,
      DP_INIT_DIV   = 4'd3,
      DP_DIV_START  = 4'd4,
      DP_DIV_STEP   = 4'd5,
      DP_NEXT_D     = 4'd6,
      DP_WRITE_HIT  = 4'd7,
      DP_WRITE_MISS = 4'd8
   } dp_op_type;

   typedef enum logic [3:0] {
      C_NEVER    = 4'd0,
      C_ALWAYS   = 4'd1,
      C_NO_REQ   = 4'd2,
      C_AT_LIMIT = 4'd3,
      C_LT4      = 4'd4,
      C_LT2      = 4'd5,
      C_EVEN     = 4'd6,
      C_SQ_GT    = 4'd7,
      C_DIV_MORE = 4'd8,
      C_REM_ZERO = 4'd9,
      C_OUT_FULL = 4'd10
   } cond_type;

   typedef struct packed {
      logic no_req;
      logic at_limit;
      logic lt4;
      logic lt2;
      logic even;
      logic sq_gt;
      logic div_more;
      logic rem_zero;
      logic out_full;
   } pns_flags_type;

   typedef struct packed {
      dp_op_type            op;
      logic                 idle;
   } pns_ctrl_type;

   typedef struct packed {
      dp_op_type            op;
      cond_type             cond;
      logic [StepWidth-1:0] target;
   } ucode_type;

   localparam logic [StepWidth-1:0] S_WAIT    = 4'd0;
   localparam logic [StepWidth-1:0] S_LIMIT   = 4'd1;
   localparam logic [StepWidth-1:0] S_STEP    = 4'd2;
   localparam logic [StepWidth-1:0] S_SMALLCK = 4'd3;
   localparam logic [StepWidth-1:0] S_EVENCK  = 4'd4;
   localparam logic [StepWidth-1:0] S_DTEST   = 4'd5;
   localparam logic [StepWidth-1:0] S_DLOOP   = 4'd6;
   localparam logic [StepWidth-1:0] S_REMCK   = 4'd7;
   localparam logic [StepWidth-1:0] S_NEXTD   = 4'd8;
   localparam logic [StepWidth-1:0] S_SMALL   = 4'd9;
   localparam logic [StepWidth-1:0] S_HIT     = 4'd10;
   localparam logic [StepWidth-1:0] S_HITDONE = 4'd11;
   localparam logic [StepWidth-1:0] S_MISS    = 4'd12;
   localparam logic [StepWidth-1:0] S_MISSEND = 4'd13;

   // control store: op, jump condition, jump target (else fall through)
   function automatic ucode_type ucode_rom(input logic [StepWidth-1:0] addr);
      ucode_type w;
      case (addr)
         S_WAIT:    w = '{DP_LOAD,       C_NO_REQ,   S_WAIT};
         S_LIMIT:   w = '{DP_NOP,        C_AT_LIMIT, S_MISS};
         S_STEP:    w = '{DP_STEP,       C_NEVER,    S_WAIT};
         S_SMALLCK: w = '{DP_NOP,        C_LT4,      S_SMALL};
         S_EVENCK:  w = '{DP_INIT_DIV,   C_EVEN,     S_LIMIT};
         S_DTEST:   w = '{DP_DIV_START,  C_SQ_GT,    S_HIT};
         S_DLOOP:   w = '{DP_DIV_STEP,   C_DIV_MORE, S_DLOOP};
         S_REMCK:   w = '{DP_NOP,        C_REM_ZERO, S_LIMIT};
         S_NEXTD:   w = '{DP_NEXT_D,     C_ALWAYS,   S_DTEST};
         S_SMALL:   w = '{DP_NOP,        C_LT2,      S_LIMIT};
         S_HIT:     w = '{DP_WRITE_HIT,  C_OUT_FULL, S_HIT};
         S_HITDONE: w = '{DP_NOP,        C_ALWAYS,   S_WAIT};
         S_MISS:    w = '{DP_WRITE_MISS, C_OUT_FULL, S_MISS};
         S_MISSEND: w = '{DP_NOP,        C_ALWAYS,   S_WAIT};
         default:   w = '{DP_NOP,        C_ALWAYS,   S_WAIT};
      endcase
      return w;
   endfunction

endpackage

// File: sv/pns_seq.sv
module pns_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  pns_pkg::pns_flags_type flags,
   output pns_pkg::pns_ctrl_type  ctrl
);
   import pns_pkg::*;

   logic [StepWidth-1:0] pc_ff;
   logic [StepWidth-1:0] pc_in;
   ucode_type            uw;
   logic                 take;

   assign uw = ucode_rom(pc_ff);

   always_comb begin
      case (uw.cond)
         C_NEVER:    take = 1'b0;
         C_ALWAYS:   take = 1'b1;
         C_NO_REQ:   take = flags.no_req;
         C_AT_LIMIT: take = flags.at_limit;
         C_LT4:      take = flags.lt4;
         C_LT2:      take = flags.lt2;
         C_EVEN:     take = flags.even;
         C_SQ_GT:    take = flags.sq_gt;
         C_DIV_MORE: take = flags.div_more;
         C_REM_ZERO: take = flags.rem_zero;
         C_OUT_FULL: take = flags.out_full;
         default:    take = 1'b1;
      endcase
   end

   assign pc_in = take ? uw.target : pc_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.op   = uw.op;
   assign ctrl.idle = (pc_ff == S_WAIT);

   a_div_loop_bounded: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == S_DLOOP) && !flags.div_more |=> (pc_ff == S_REMCK))
      else $error("divide loop did not exit to remainder check");

endmodule

// File: sv/prime_neighbour_search.sv
// Operation: each candidate is screened, then trial-divided by every odd divisor d
//   with d*d <= candidate (up to ~32768 divisors for a 32-bit prime), and then the
//   result is posted; many candidates may be tried per search.
// Throughput: one transaction at a time; the next request is taken once the result
//   is posted to the output register, which may still be waiting on rsp_stall.
// Reset: clears the step counter and the output valid; datapath registers are not reset.
module prime_neighbour_search (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pns_pkg::pns_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pns_pkg::pns_rsp_type rsp_data
);
   import pns_pkg::*;

   pns_ctrl_type         ctrl;
   pns_flags_type        flags;

   logic                   dir_ff;
   logic                   dir_in;
   logic [ValueWidth-1:0]  c_ff;
   logic [ValueWidth-1:0]  c_in;
   logic [DivWidth-1:0]    d_ff;
   logic [DivWidth-1:0]    d_in;
   logic [SqWidth-1:0]     sq_ff;
   logic [SqWidth-1:0]     sq_in;
   logic [DivWidth-1:0]    rem_ff;
   logic [DivWidth-1:0]    rem_in;
   logic [ValueWidth-1:0]  dvd_ff;
   logic [ValueWidth-1:0]  dvd_in;
   logic [DivCntWidth-1:0] cnt_ff;
   logic [DivCntWidth-1:0] cnt_in;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   pns_rsp_type            out_data_ff;
   pns_rsp_type            out_data_in;

   logic                   accept;
   logic [DivWidth:0]      trial;
   logic [DivWidth:0]      diff;
   logic                   ge;
   logic                   wr_en;

   pns_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   assign accept    = ctrl.idle && req_valid;
   assign req_stall = !ctrl.idle;

   assign trial = {rem_ff, dvd_ff[ValueWidth-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign ge    = (trial >= {1'b0, d_ff});

   assign flags.no_req   = !req_valid;
   assign flags.at_limit = dir_ff ? (c_ff <= ValueWidth'(2)) : (c_ff == '1);
   assign flags.lt4      = (c_ff < ValueWidth'(4));
   assign flags.lt2      = (c_ff < ValueWidth'(2));
   assign flags.even     = !c_ff[0];
   assign flags.sq_gt    = (sq_ff > {2'b00, c_ff});
   assign flags.div_more = (cnt_ff != '1);
   assign flags.rem_zero = (rem_ff == '0);
   assign flags.out_full = out_valid_ff;

   assign wr_en = ((ctrl.op == DP_WRITE_HIT) || (ctrl.op == DP_WRITE_MISS)) && !out_valid_ff;

   always_comb begin
      dir_in      = dir_ff;
      c_in        = c_ff;
      d_in        = d_ff;
      sq_in       = sq_ff;
      rem_in      = rem_ff;
      dvd_in      = dvd_ff;
      cnt_in      = cnt_ff;
      out_data_in = out_data_ff;
      case (ctrl.op)
         DP_LOAD: begin
            if (accept) begin
               dir_in = req_data.op;
               c_in   = req_data.start_value;
            end
         end
         DP_STEP: begin
            c_in = dir_ff ? c_ff - 1'b1 : c_ff + 1'b1;
         end
         DP_INIT_DIV: begin
            d_in  = DivWidth'(3);
            sq_in = SqWidth'(9);
         end
         DP_DIV_START: begin
            rem_in = '0;
            dvd_in = c_ff;
            cnt_in = '0;
         end
         DP_DIV_STEP: begin
            rem_in = ge ? diff[DivWidth-1:0] : trial[DivWidth-1:0];
            dvd_in = {dvd_ff[ValueWidth-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
         end
         DP_NEXT_D: begin
            d_in  = d_ff + DivWidth'(2);
            sq_in = sq_ff + SqWidth'({d_ff, 2'b00}) + SqWidth'(4);
         end
         DP_WRITE_HIT: begin
            if (wr_en) begin
               out_data_in.found       = 1'b1;
               out_data_in.prime_value = c_ff;
            end
         end
         DP_WRITE_MISS: begin
            if (wr_en) begin
               out_data_in.found       = 1'b0;
               out_data_in.prime_value = '0;
            end
         end
         default: begin
         end
      endcase
   end

   assign out_valid_in = wr_en || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff      <= dir_in;
      c_ff        <= c_in;
      d_ff        <= d_in;
      sq_ff       <= sq_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      cnt_ff      <= cnt_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> (rsp_data.prime_value == '0))
      else $error("not-found result carries a nonzero value");

   a_hit_ge2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> (rsp_data.prime_value >= ValueWidth'(2)))
      else $error("found result below 2");

   a_div_odd: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == DP_DIV_STEP) |-> (d_ff[0] && (d_ff >= DivWidth'(3))))
      else $error("trial divisor not odd or below 3");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == DP_DIV_STEP) |-> (rem_ff < d_ff))
      else $error("partial remainder not below divisor");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> $stable(out_data_ff))
      else $error("pending result overwritten");

endmodule
